>>> sv/csv_field_splitter_defines.svh
// Assertion macros used by the checker file of the CSV field splitter.
`ifndef CSV_FIELD_SPLITTER_DEFINES_SVH
`define CSV_FIELD_SPLITTER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define CSVFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define CSVFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/csvfs_pkg.sv
package csvfs_pkg;

  localparam int COUNT_BITS = 24;
  localparam int OUT_BITS   = 24;
  localparam int STEP_W     = $clog2(COUNT_BITS + 1);

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [OUT_BITS-1:0]   out_cnt_t;

  localparam cnt_t CNT_MAX = '1;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_FIELD  = 2'd1,
    KIND_ROW    = 2'd2,
    KIND_STATUS = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    Q_NORMAL = 3'b001,
    Q_IN     = 3'b010,
    Q_SEEN   = 3'b100
  } quote_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_POST = 3'b100
  } state_t;

  typedef struct packed {
    logic       emit;
    kind_t      kind;
    logic [7:0] data;
  } parse_emit_t;

  typedef struct packed {
    cnt_t rows;
    cnt_t fields;
    logic ovf;
    logic in_quotes;
  } parse_stat_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
    cnt_t quotient;
  } div_rsp_t;

  function automatic out_cnt_t to_out(input cnt_t v);
    logic [63:0] wide;
    wide = 64'(v);
    return wide[OUT_BITS-1:0];
  endfunction

endpackage

>>> sv/csvfs_if.sv
interface csvfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_end;

  modport source (output valid, output in_byte, output is_end, input ready);
  modport sink (input valid, input in_byte, input is_end, output ready);
  modport monitor (input valid, input ready, input in_byte, input is_end);
endinterface

interface csvfs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic        status_ok;
  logic [23:0] row_count;
  logic [23:0] total_fields;
  logic [23:0] fields_per_row;

  modport source (output valid, output kind, output data_byte, output status_ok,
                  output row_count, output total_fields, output fields_per_row,
                  input ready);
  modport sink (input valid, input kind, input data_byte, input status_ok,
                input row_count, input total_fields, input fields_per_row,
                output ready);
  modport monitor (input valid, input ready, input kind, input data_byte,
                   input status_ok, input row_count, input total_fields,
                   input fields_per_row);
endinterface

>>> sv/csvfs_div.sv
module csvfs_div import csvfs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  cnt_t     dividend,
  input  cnt_t     divisor,
  output div_rsp_t rsp
);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              done_r, done_nxt;
  cnt_t              quo_r, quo_nxt;
  cnt_t              rem_r, rem_nxt;
  logic [COUNT_BITS:0] trial;

  always_comb begin
    trial    = {rem_r, quo_r[COUNT_BITS-1]};
    step_nxt = step_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      step_nxt = STEP_W'(COUNT_BITS);
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (step_r != '0) begin
      step_nxt = step_r - 1'b1;
      done_nxt = (step_r == STEP_W'(1));
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = cnt_t'(trial - {1'b0, divisor});
        quo_nxt = {quo_r[COUNT_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[COUNT_BITS-1:0];
        quo_nxt = {quo_r[COUNT_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.rem_zero = (rem_r == '0);
  assign rsp.quotient = quo_r;

endmodule

>>> sv/csvfs_parse.sv
module csvfs_parse import csvfs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  in_byte,
  input  logic        clear,
  output parse_emit_t emit,
  output parse_stat_t stat
);

  quote_t qm_r, qm_nxt;
  cnt_t   rows_r, rows_nxt;
  cnt_t   fields_r, fields_nxt;
  logic   ovf_r, ovf_nxt;
  logic   as_normal;

  always_comb begin
    qm_nxt     = qm_r;
    rows_nxt   = rows_r;
    fields_nxt = fields_r;
    ovf_nxt    = ovf_r;
    as_normal  = 1'b0;
    emit       = '{emit: 1'b0, kind: KIND_DATA, data: 8'h00};
    if (clear) begin
      qm_nxt     = Q_NORMAL;
      rows_nxt   = '0;
      fields_nxt = '0;
      ovf_nxt    = 1'b0;
    end else if (step) begin
      case (qm_r)
        Q_IN: begin
          if (in_byte == CH_QUOTE) begin
            qm_nxt = Q_SEEN;
          end else begin
            emit = '{emit: 1'b1, kind: KIND_DATA, data: in_byte};
          end
        end
        Q_SEEN: begin
          if (in_byte == CH_QUOTE) begin
            qm_nxt = Q_IN;
            emit   = '{emit: 1'b1, kind: KIND_DATA, data: in_byte};
          end else begin
            qm_nxt    = Q_NORMAL;
            as_normal = 1'b1;
          end
        end
        default: as_normal = 1'b1;
      endcase
      if (as_normal) begin
        case (in_byte)
          CH_QUOTE: qm_nxt = Q_IN;
          CH_COMMA: begin
            if (fields_r == CNT_MAX) ovf_nxt = 1'b1;
            else fields_nxt = fields_r + 1'b1;
            emit = '{emit: 1'b1, kind: KIND_FIELD, data: 8'h00};
          end
          CH_CR: ;
          CH_LF: begin
            if (fields_r == CNT_MAX) ovf_nxt = 1'b1;
            else fields_nxt = fields_r + 1'b1;
            if (rows_r == CNT_MAX) ovf_nxt = 1'b1;
            else rows_nxt = rows_r + 1'b1;
            emit = '{emit: 1'b1, kind: KIND_ROW, data: 8'h00};
          end
          default: emit = '{emit: 1'b1, kind: KIND_DATA, data: in_byte};
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qm_r     <= Q_NORMAL;
      rows_r   <= '0;
      fields_r <= '0;
      ovf_r    <= 1'b0;
    end else begin
      qm_r     <= qm_nxt;
      rows_r   <= rows_nxt;
      fields_r <= fields_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  assign stat.rows      = rows_r;
  assign stat.fields    = fields_r;
  assign stat.ovf       = ovf_r;
  assign stat.in_quotes = (qm_r != Q_NORMAL);

endmodule

>>> sv/csv_field_splitter.sv
// CSV field splitter. Text enters on in_ch one byte per transfer; a transfer
// with is_end set closes the text and asks for the final status. Results
// leave on out_ch: content bytes, field-end and row-end markers, and one
// status item per end transfer with row count, field count, fields per row
// and a valid flag.
// A text byte's result, if any, is registered and shown the cycle after its
// transfer, so bytes stream at one per cycle while out_ch keeps up. Quote
// characters and carriage returns outside quotes give no result.
// An end transfer that passes the quote, row and overflow checks runs a
// restoring divider, one quotient bit per cycle, and its status item is
// registered from S_POST once the divider is done and out_ch has room.
// An end transfer that fails those checks skips the divider and goes
// straight to S_POST, where its status item waits until out_ch has room.
// in_ch is not ready meanwhile. After the status item is loaded, all parse
// state is back at its reset values.
// If out_ch stalls, the result register holds and in_ch drops ready until
// the waiting result is transferred.
// Reset (rst_n low at a clock edge) clears the quote state, the counters and
// the result valid flag.
module csv_field_splitter import csvfs_pkg::*; (
  input logic clk,
  input logic rst_n,
  csvfs_in_if.sink    in_ch,
  csvfs_out_if.source out_ch
);

  state_t      state_r, state_nxt;
  logic        pre_ok_r, pre_ok_nxt;
  logic        out_valid_r, out_valid_nxt;
  kind_t       out_kind_r, out_kind_nxt;
  logic [7:0]  out_data_r, out_data_nxt;
  logic        out_ok_r, out_ok_nxt;
  out_cnt_t    out_rows_r, out_rows_nxt;
  out_cnt_t    out_fields_r, out_fields_nxt;
  out_cnt_t    out_per_r, out_per_nxt;

  logic        slot_free;
  logic        in_xfer;
  logic        byte_step;
  logic        div_start;
  logic        post_load;
  logic        final_ok;
  parse_emit_t emit;
  parse_stat_t stat;
  div_rsp_t    div_rsp;

  assign slot_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE) && slot_free;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign byte_step    = in_xfer && !in_ch.is_end;
  assign post_load    = (state_r == S_POST) && slot_free;
  assign final_ok     = pre_ok_r && div_rsp.rem_zero;

  csvfs_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (byte_step),
    .in_byte (in_ch.in_byte),
    .clear   (post_load),
    .emit    (emit),
    .stat    (stat)
  );

  csvfs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (stat.fields),
    .divisor  (stat.rows),
    .rsp      (div_rsp)
  );

  always_comb begin
    state_nxt      = state_r;
    pre_ok_nxt     = pre_ok_r;
    div_start      = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_kind_nxt   = out_kind_r;
    out_data_nxt   = out_data_r;
    out_ok_nxt     = out_ok_r;
    out_rows_nxt   = out_rows_r;
    out_fields_nxt = out_fields_r;
    out_per_nxt    = out_per_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer && in_ch.is_end) begin
          pre_ok_nxt = !stat.in_quotes && (stat.rows != '0) && !stat.ovf;
          if (pre_ok_nxt) begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_POST;
          end
        end else if (byte_step && emit.emit) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = emit.kind;
          out_data_nxt   = emit.data;
          out_ok_nxt     = 1'b0;
          out_rows_nxt   = '0;
          out_fields_nxt = '0;
          out_per_nxt    = '0;
        end
      end
      S_DIV: begin
        if (div_rsp.done) state_nxt = S_POST;
      end
      S_POST: begin
        if (post_load) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_STATUS;
          out_data_nxt   = 8'h00;
          out_ok_nxt     = final_ok;
          out_rows_nxt   = to_out(stat.rows);
          out_fields_nxt = to_out(stat.fields);
          out_per_nxt    = final_ok ? to_out(div_rsp.quotient) : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pre_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pre_ok_r    <= pre_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_kind_r   <= out_kind_nxt;
    out_data_r   <= out_data_nxt;
    out_ok_r     <= out_ok_nxt;
    out_rows_r   <= out_rows_nxt;
    out_fields_r <= out_fields_nxt;
    out_per_r    <= out_per_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = out_kind_r;
  assign out_ch.data_byte      = out_data_r;
  assign out_ch.status_ok      = out_ok_r;
  assign out_ch.row_count      = out_rows_r;
  assign out_ch.total_fields   = out_fields_r;
  assign out_ch.fields_per_row = out_per_r;

endmodule

>>> sv/csvfs_checker.sv
`include "csv_field_splitter_defines.svh"

module csvfs_checker import csvfs_pkg::*; (
  input logic clk,
  input logic rst_n,
  csvfs_in_if.sink     in_ch,
  csvfs_out_if.source  out_ch
);

  `CSVFS_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.kind) && $stable(out_ch.data_byte), "Stalled result changed before its transfer.")
  `CSVFS_ASSERT_NEXT(a_end_busy, in_ch.valid && in_ch.ready && in_ch.is_end, !in_ch.ready, "Input ready right after an end transfer.")
  `CSVFS_ASSERT_NOW(a_marker_zero, out_ch.valid && (out_ch.kind != KIND_DATA), out_ch.data_byte == 8'h00, "Marker or status item carries a nonzero data byte.")
  `CSVFS_ASSERT_NOW(a_per_only_ok, out_ch.valid && (out_ch.fields_per_row != '0), out_ch.status_ok && (out_ch.kind == KIND_STATUS), "Fields per row reported without a valid status.")
  `CSVFS_ASSERT_NOW(a_ok_has_rows, out_ch.valid && out_ch.status_ok, (out_ch.kind == KIND_STATUS) && (out_ch.row_count != '0 || COUNT_BITS > OUT_BITS), "Valid status with no completed row.")

endmodule

bind csv_field_splitter csvfs_checker u_csvfs_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import csvfs_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int ITEM_GOAL  = 1400;

  typedef enum logic [1:0] {
    QS_PLAIN       = 2'd0,
    QS_QUOTED      = 2'd1,
    QS_AFTER_QUOTE = 2'd2
  } quote_state_t;

  typedef enum logic [1:0] {
    RX_OPEN   = 2'd0,
    RX_RANDOM = 2'd1,
    RX_BURSTY = 2'd2
  } rx_mode_t;

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic       ok;
    out_cnt_t   rows;
    out_cnt_t   fields;
    out_cnt_t   per;
  } csv_token_t;

  class csv_token_scoreboard;
    quote_state_t mode;
    cnt_t         rows;
    cnt_t         fields;
    logic         ovf;
    csv_token_t   want_tokens[$];
    int           errors;

    function new();
      errors = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      mode   = QS_PLAIN;
      rows   = '0;
      fields = '0;
      ovf    = 1'b0;
    endfunction

    function cnt_t sat_inc(input cnt_t c);
      if (c == CNT_MAX) begin
        ovf = 1'b1;
        return c;
      end
      return c + 1'b1;
    endfunction

    function int pending();
      return want_tokens.size();
    endfunction

    function void accept_item(input logic [7:0] b, input logic e);
      csv_token_t tok;
      logic       ok;
      bit         emit;
      bit         plain;
      emit  = 0;
      plain = 0;
      tok   = '{kind: KIND_DATA, data: 8'h00, ok: 1'b0, rows: '0, fields: '0, per: '0};
      if (e) begin
        ok = (mode == QS_PLAIN) && (rows != 0) && !ovf;
        if (ok && (fields % rows) != 0) ok = 1'b0;
        tok.kind   = KIND_STATUS;
        tok.ok     = ok;
        tok.rows   = out_cnt_t'(rows);
        tok.fields = out_cnt_t'(fields);
        if (ok) tok.per = out_cnt_t'(fields / rows);
        emit = 1;
        clear_parse();
      end else begin
        case (mode)
          QS_QUOTED: begin
            if (b == CH_QUOTE) begin
              mode = QS_AFTER_QUOTE;
            end else begin
              tok.data = b;
              emit = 1;
            end
          end
          QS_AFTER_QUOTE: begin
            if (b == CH_QUOTE) begin
              mode = QS_QUOTED;
              tok.data = b;
              emit = 1;
            end else begin
              mode = QS_PLAIN;
              plain = 1;
            end
          end
          default: plain = 1;
        endcase
        if (plain) begin
          case (b)
            CH_QUOTE: mode = QS_QUOTED;
            CH_COMMA: begin
              fields = sat_inc(fields);
              tok.kind = KIND_FIELD;
              emit = 1;
            end
            CH_CR: ;
            CH_LF: begin
              fields = sat_inc(fields);
              rows = sat_inc(rows);
              tok.kind = KIND_ROW;
              emit = 1;
            end
            default: begin
              tok.data = b;
              emit = 1;
            end
          endcase
        end
      end
      if (emit) want_tokens.push_back(tok);
    endfunction

    function void check_token(input logic [1:0] kind, input logic [7:0] data,
                              input logic ok, input out_cnt_t rcount,
                              input out_cnt_t fcount, input out_cnt_t per);
      csv_token_t exp;
      if (want_tokens.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind %0d data %h ok %b rows %0d fields %0d per %0d",
                   kind, data, ok, rcount, fcount, per);
        return;
      end
      exp = want_tokens.pop_front();
      if (kind !== exp.kind || data !== exp.data || ok !== exp.ok ||
          rcount !== exp.rows || fcount !== exp.fields || per !== exp.per) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected kind %0d data %h ok %b rows %0d fields %0d per %0d",
                   exp.kind, exp.data, exp.ok, exp.rows, exp.fields, exp.per);
          $display("          actual   kind %0d data %h ok %b rows %0d fields %0d per %0d",
                   kind, data, ok, rcount, fcount, per);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  csvfs_in_if  in_ch();
  csvfs_out_if out_ch();

  csv_field_splitter DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  csv_token_scoreboard sb;
  int       items_sent = 0;
  int       burst_left = 0;
  int       idle_cycles = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_phase_left = 0;
  int       rx_hold_left = 0;

  always #1 clk = ~clk;

  function automatic logic [7:0] text_char(input bit any);
    logic [7:0] c;
    if (any && $urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0:       c = CH_QUOTE;
        1:       c = CH_COMMA;
        2:       c = CH_CR;
        default: c = CH_LF;
      endcase
      return c;
    end
    do begin
      c = 8'($urandom_range(0, 255));
    end while (!any && (c == CH_QUOTE || c == CH_COMMA || c == CH_CR || c == CH_LF));
    return c;
  endfunction

  task automatic send_item(input logic [7:0] b, input logic e);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 5))
        0, 1:    gap = 0;
        5:       gap = $urandom_range(9, 25);
        default: gap = $urandom_range(1, 8);
      endcase
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.is_end  <= e;
    do @(posedge clk); while (!in_ch.ready);
    sb.accept_item(b, e);
    items_sent++;
    burst_left--;
  endtask

  always @(negedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode       <= rx_mode_t'($urandom_range(0, 2));
      rx_phase_left <= $urandom_range(20, 200);
    end else begin
      rx_phase_left <= rx_phase_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ch.ready <= 1'b1;
      RX_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_hold_left == 0) begin
          out_ch.ready <= ~out_ch.ready;
          rx_hold_left <= $urandom_range(1, 12);
        end else begin
          rx_hold_left <= rx_hold_left - 1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_token(out_ch.kind, out_ch.data_byte, out_ch.status_ok, out_ch.row_count,
                     out_ch.total_fields, out_ch.fields_per_row);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [8:0] directed_text[$];
    int         rows;
    int         cols;
    int         width;
    int         len;
    int         tail;
    int         doc_no;
    bit         quoted;
    logic [7:0] c;
    sb = new();
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.is_end  = 1'b0;
    out_ch.ready  = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // An empty parse, a plain row with a zero byte, a quoted field holding
    // every special character, uneven rows, and ends inside a quoted span.
    directed_text = '{
      9'h100,
      9'h078, {1'b0, CH_COMMA}, 9'h000, {1'b0, CH_LF}, 9'h155,
      {1'b0, CH_QUOTE}, 9'h0FF, {1'b0, CH_COMMA}, {1'b0, CH_QUOTE}, {1'b0, CH_QUOTE},
      {1'b0, CH_CR}, {1'b0, CH_LF}, {1'b0, CH_QUOTE}, {1'b0, CH_CR}, {1'b0, CH_LF},
      9'h100,
      9'h062, {1'b0, CH_LF}, {1'b0, CH_COMMA}, {1'b0, CH_LF}, 9'h1FF,
      {1'b0, CH_QUOTE}, 9'h071, 9'h1AA,
      {1'b0, CH_LF}, {1'b0, CH_QUOTE}, {1'b0, CH_QUOTE}, 9'h100
    };
    foreach (directed_text[i]) send_item(directed_text[i][7:0], directed_text[i][8]);

    doc_no = 0;
    while (items_sent < ITEM_GOAL) begin
      rows = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
      cols = $urandom_range(1, 4);
      for (int r = 0; r < rows; r++) begin
        width = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : cols;
        for (int f = 0; f < width; f++) begin
          quoted = ($urandom_range(0, 2) == 0);
          len = $urandom_range(0, 5);
          if (quoted) send_item(CH_QUOTE, 1'b0);
          repeat (len) begin
            c = text_char(quoted);
            send_item(c, 1'b0);
            if (quoted && c == CH_QUOTE) send_item(CH_QUOTE, 1'b0);
          end
          if (quoted) send_item(CH_QUOTE, 1'b0);
          if ($urandom_range(0, 11) == 0) send_item(text_char(1'b1), 1'b0);
          if (f < width - 1) send_item(CH_COMMA, 1'b0);
        end
        if ($urandom_range(0, 2) == 0) send_item(CH_CR, 1'b0);
        send_item(CH_LF, 1'b0);
      end
      tail = $urandom_range(0, 15);
      if (tail == 0) begin
        send_item(CH_QUOTE, 1'b0);
        if ($urandom_range(0, 1) == 1) send_item(text_char(1'b1), 1'b0);
      end else if (tail == 1) begin
        send_item(text_char(1'b0), 1'b0);
      end
      send_item(8'($urandom_range(0, 255)), 1'b1);
      if (doc_no == 0 || $urandom_range(0, 7) == 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      doc_no++;
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
